// ===== hw/rtl/prvp_pkg.sv =====
package prvp_pkg;

    localparam int DOTS_PER_LINE_DEF   = 341;
    localparam int LINES_PER_FRAME_DEF = 262;
    localparam int VBLANK_LINE_DEF     = 241;
    localparam int PATTERN_DEPTH_DEF   = 8192;

    localparam int QUEUE_DEPTH  = 4;
    localparam int PAT_ADDR_W   = 13;
    localparam int NT_DEPTH     = 2048;
    localparam int OAM_DEPTH    = 256;
    localparam int PAL_DEPTH    = 32;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    localparam logic [2:0] REG_CTRL    = 3'd0;
    localparam logic [2:0] REG_MASK    = 3'd1;
    localparam logic [2:0] REG_STATUS  = 3'd2;
    localparam logic [2:0] REG_OAMADDR = 3'd3;
    localparam logic [2:0] REG_OAMDATA = 3'd4;
    localparam logic [2:0] REG_SCROLL  = 3'd5;
    localparam logic [2:0] REG_ADDR    = 3'd6;
    localparam logic [2:0] REG_DATA    = 3'd7;

    typedef enum logic [2:0] {
        SRC_IMM,
        SRC_OAM,
        SRC_PAT,
        SRC_NT,
        SRC_PAL
    } src_t;

    typedef struct packed {
        logic                  oam_we;
        logic                  pat_we;
        logic                  nt_we;
        logic                  pal_we;
        logic [7:0]            spr_addr;
        logic [PAT_ADDR_W-1:0] pat_addr;
        logic [10:0]           nt_addr;
        logic [4:0]            pal_addr;
        logic [7:0]            wdata;
    } mem_req_t;

    typedef struct packed {
        logic       valid;
        src_t       src;
        logic [7:0] imm;
        logic       nmi;
        logic       vblank;
    } res_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       nmi;
        logic       vblank;
    } out_t;

    typedef struct packed {
        logic [7:0] oam;
        logic [7:0] pat;
        logic [7:0] nt;
        logic [7:0] pal;
    } mem_rd_t;

endpackage

// ===== hw/rtl/prvp_front.sv =====
module prvp_front #(
    parameter int DOTS_PER_LINE   = prvp_pkg::DOTS_PER_LINE_DEF,
    parameter int LINES_PER_FRAME = prvp_pkg::LINES_PER_FRAME_DEF,
    parameter int VBLANK_LINE     = prvp_pkg::VBLANK_LINE_DEF,
    parameter int PATTERN_DEPTH   = prvp_pkg::PATTERN_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic [2:0]         reg_sel,
    input  logic [7:0]         wdata,
    input  logic               cfg_valid,
    input  logic               cfg_mirror,
    input  logic               clear_done,
    input  logic               room,
    output prvp_pkg::mem_req_t mem_req,
    output prvp_pkg::res_t     res
);

    localparam int DOT_W  = $clog2(DOTS_PER_LINE);
    localparam int LINE_W = $clog2(LINES_PER_FRAME);
    localparam logic [15:0] PD1 = 16'(PATTERN_DEPTH);
    localparam logic [15:0] PD2 = 16'(2 * PATTERN_DEPTH);
    localparam logic [15:0] PD4 = 16'(4 * PATTERN_DEPTH);

    logic [14:0]       cur_reg, cur_next;
    logic [14:0]       tmp_reg, tmp_next;
    logic [2:0]        fine_reg, fine_next;
    logic              toggle_reg, toggle_next;
    logic [7:0]        ctrl_reg, ctrl_next;
    logic [7:0]        mask_reg, mask_next;
    logic [7:0]        status_reg, status_next;
    logic [7:0]        ptr_reg, ptr_next;
    logic [7:0]        scroll_reg, scroll_next;
    logic [7:0]        addr_reg, addr_next;
    logic [DOT_W-1:0]  dot_reg, dot_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic              mirror_reg;
    prvp_pkg::res_t    res_reg, res_next;

    logic              accept;
    logic [13:0]       pa;
    logic [15:0]       pr0, pr1, pr2, pr3;
    logic [4:0]        pal_idx;
    prvp_pkg::src_t    port_src;
    logic [14:0]       step;

    assign in_ready = clear_done && room;
    assign accept   = in_valid && in_ready;
    assign res      = res_reg;

    // port address decode
    always_comb
    begin
        pa  = cur_reg[13:0];
        pr0 = {3'b000, pa[12:0]};
        pr1 = (pr0 >= PD4) ? pr0 - PD4 : pr0;
        pr2 = (pr1 >= PD2) ? pr1 - PD2 : pr1;
        pr3 = (pr2 >= PD1) ? pr2 - PD1 : pr2;
        pal_idx = pa[4:0];
        if (pal_idx[4] && (pal_idx[1:0] == 2'b00))
        begin
            pal_idx[4] = 1'b0;
        end
        if (!pa[13])
        begin
            port_src = prvp_pkg::SRC_PAT;
        end
        else if (pa[13:8] != 6'h3F)
        begin
            port_src = prvp_pkg::SRC_NT;
        end
        else
        begin
            port_src = prvp_pkg::SRC_PAL;
        end
        step = ctrl_reg[2] ? 15'd32 : 15'd1;
    end

    always_comb
    begin
        mem_req          = '0;
        mem_req.spr_addr = ptr_reg;
        mem_req.pat_addr = pr3[prvp_pkg::PAT_ADDR_W-1:0];
        mem_req.nt_addr  = {mirror_reg ? pa[11] : pa[10], pa[9:0]};
        mem_req.pal_addr = pal_idx;
        mem_req.wdata    = wdata;

        cur_next    = cur_reg;
        tmp_next    = tmp_reg;
        fine_next   = fine_reg;
        toggle_next = toggle_reg;
        ctrl_next   = ctrl_reg;
        mask_next   = mask_reg;
        status_next = status_reg;
        ptr_next    = ptr_reg;
        scroll_next = scroll_reg;
        addr_next   = addr_reg;
        dot_next    = dot_reg;
        line_next   = line_reg;

        res_next       = '0;
        res_next.valid = accept;
        res_next.src   = prvp_pkg::SRC_IMM;

        if (accept)
        begin
            case (prvp_pkg::action_t'(action))
                prvp_pkg::ACT_TICK:
                begin
                    if (line_reg == LINE_W'(LINES_PER_FRAME - 1) && dot_reg == DOT_W'(1))
                    begin
                        status_next = status_next & 8'h1F;
                    end
                    if (line_reg == LINE_W'(VBLANK_LINE) && dot_reg == DOT_W'(1))
                    begin
                        status_next[7] = 1'b1;
                        res_next.nmi   = ctrl_reg[7];
                    end
                    if (dot_reg == DOT_W'(DOTS_PER_LINE - 1))
                    begin
                        dot_next = '0;
                        if (line_reg == LINE_W'(LINES_PER_FRAME - 1))
                        begin
                            line_next = '0;
                        end
                        else
                        begin
                            line_next = line_reg + LINE_W'(1);
                        end
                    end
                    else
                    begin
                        dot_next = dot_reg + DOT_W'(1);
                    end
                end
                prvp_pkg::ACT_READ:
                begin
                    unique case (reg_sel)
                        prvp_pkg::REG_CTRL:    res_next.imm = ctrl_reg;
                        prvp_pkg::REG_MASK:    res_next.imm = mask_reg;
                        prvp_pkg::REG_STATUS:
                        begin
                            res_next.imm   = status_reg;
                            status_next[7] = 1'b0;
                            toggle_next    = 1'b0;
                        end
                        prvp_pkg::REG_OAMADDR: res_next.imm = ptr_reg;
                        prvp_pkg::REG_OAMDATA: res_next.src = prvp_pkg::SRC_OAM;
                        prvp_pkg::REG_SCROLL:  res_next.imm = scroll_reg;
                        prvp_pkg::REG_ADDR:    res_next.imm = addr_reg;
                        default:
                        begin
                            res_next.src = port_src;
                            cur_next     = cur_reg + step;
                        end
                    endcase
                end
                prvp_pkg::ACT_WRITE:
                begin
                    unique case (reg_sel)
                        prvp_pkg::REG_CTRL:
                        begin
                            ctrl_next = wdata;
                            tmp_next  = {tmp_reg[14:12], wdata[1:0], tmp_reg[9:0]};
                        end
                        prvp_pkg::REG_MASK:    mask_next = wdata;
                        prvp_pkg::REG_STATUS:  ;
                        prvp_pkg::REG_OAMADDR: ptr_next = wdata;
                        prvp_pkg::REG_OAMDATA:
                        begin
                            mem_req.oam_we = 1'b1;
                            ptr_next       = ptr_reg + 8'd1;
                        end
                        prvp_pkg::REG_SCROLL:
                        begin
                            scroll_next = wdata;
                            toggle_next = !toggle_reg;
                            if (!toggle_reg)
                            begin
                                tmp_next  = {tmp_reg[14:5], wdata[7:3]};
                                fine_next = wdata[2:0];
                            end
                            else
                            begin
                                tmp_next = {wdata[2:0], tmp_reg[11:10], wdata[7:3], tmp_reg[4:0]};
                            end
                        end
                        prvp_pkg::REG_ADDR:
                        begin
                            addr_next   = wdata;
                            toggle_next = !toggle_reg;
                            if (!toggle_reg)
                            begin
                                tmp_next = {1'b0, wdata[5:0], tmp_reg[7:0]};
                            end
                            else
                            begin
                                tmp_next = {tmp_reg[14:8], wdata};
                                cur_next = {tmp_reg[14:8], wdata};
                            end
                        end
                        default:
                        begin
                            mem_req.pat_we = (port_src == prvp_pkg::SRC_PAT);
                            mem_req.nt_we  = (port_src == prvp_pkg::SRC_NT);
                            mem_req.pal_we = (port_src == prvp_pkg::SRC_PAL);
                            cur_next       = cur_reg + step;
                        end
                    endcase
                end
                default: ;
            endcase
        end
        res_next.vblank = status_next[7];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg    <= '0;
            tmp_reg    <= '0;
            fine_reg   <= '0;
            toggle_reg <= 1'b0;
            ctrl_reg   <= '0;
            mask_reg   <= '0;
            status_reg <= '0;
            ptr_reg    <= '0;
            scroll_reg <= '0;
            addr_reg   <= '0;
            dot_reg    <= '0;
            line_reg   <= LINE_W'(LINES_PER_FRAME - 1);
            mirror_reg <= 1'b0;
            res_reg    <= '0;
        end
        else
        begin
            cur_reg    <= cur_next;
            tmp_reg    <= tmp_next;
            fine_reg   <= fine_next;
            toggle_reg <= toggle_next;
            ctrl_reg   <= ctrl_next;
            mask_reg   <= mask_next;
            status_reg <= status_next;
            ptr_reg    <= ptr_next;
            scroll_reg <= scroll_next;
            addr_reg   <= addr_next;
            dot_reg    <= dot_next;
            line_reg   <= line_next;
            res_reg    <= res_next;
            if (cfg_valid)
            begin
                mirror_reg <= cfg_mirror;
            end
        end
    end

    // fine x is kept for the renderer side, which is not part of this block
    logic unused_fine;
    assign unused_fine = ^fine_reg;

endmodule

// ===== hw/rtl/prvp_mem.sv =====
module prvp_mem #(
    parameter int PATTERN_DEPTH = prvp_pkg::PATTERN_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  prvp_pkg::mem_req_t mem_req,
    output prvp_pkg::mem_rd_t  mem_rd,
    output logic               clear_done
);

    localparam int PAT_AW    = $clog2(PATTERN_DEPTH);
    localparam int CLR_DEPTH = (PATTERN_DEPTH > prvp_pkg::NT_DEPTH) ?
                               PATTERN_DEPTH : prvp_pkg::NT_DEPTH;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    logic [7:0] oam_mem [prvp_pkg::OAM_DEPTH];
    logic [7:0] pat_mem [PATTERN_DEPTH];
    logic [7:0] nt_mem  [prvp_pkg::NT_DEPTH];
    logic [7:0] pal_reg [prvp_pkg::PAL_DEPTH];

    logic [CLR_W-1:0] clr_cnt_reg;
    logic             clearing_reg;
    logic [7:0]       oam_rd_reg, pat_rd_reg, nt_rd_reg, pal_rd_reg;

    assign clear_done = !clearing_reg;
    assign mem_rd     = '{oam: oam_rd_reg, pat: pat_rd_reg, nt: nt_rd_reg, pal: pal_rd_reg};

    // one pass over all big memories after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
            if (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            oam_mem[clr_cnt_reg[7:0]] <= 8'h00;
        end
        else if (mem_req.oam_we)
        begin
            oam_mem[mem_req.spr_addr] <= mem_req.wdata;
        end
        oam_rd_reg <= oam_mem[mem_req.spr_addr];
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            if (clr_cnt_reg < CLR_W'(PATTERN_DEPTH - 1) || clr_cnt_reg == CLR_W'(PATTERN_DEPTH - 1))
            begin
                pat_mem[clr_cnt_reg[PAT_AW-1:0]] <= 8'h00;
            end
        end
        else if (mem_req.pat_we)
        begin
            pat_mem[mem_req.pat_addr[PAT_AW-1:0]] <= mem_req.wdata;
        end
        pat_rd_reg <= pat_mem[mem_req.pat_addr[PAT_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            nt_mem[clr_cnt_reg[10:0]] <= 8'h00;
        end
        else if (mem_req.nt_we)
        begin
            nt_mem[mem_req.nt_addr] <= mem_req.wdata;
        end
        nt_rd_reg <= nt_mem[mem_req.nt_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < prvp_pkg::PAL_DEPTH; i++)
            begin
                pal_reg[i] <= 8'h00;
            end
        end
        else if (mem_req.pal_we)
        begin
            pal_reg[mem_req.pal_addr] <= mem_req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        pal_rd_reg <= pal_reg[mem_req.pal_addr];
    end

endmodule

// ===== hw/rtl/prvp_queue.sv =====
module prvp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  prvp_pkg::res_t    res,
    input  prvp_pkg::mem_rd_t mem_rd,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output prvp_pkg::out_t    out_item,
    output logic [2:0]        level
);

    localparam int PTR_W = $clog2(prvp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    prvp_pkg::out_t   q_reg [prvp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    prvp_pkg::out_t   push_item;
    logic             push, pop;

    // merge the memory read that the front issued in the previous cycle
    always_comb
    begin
        push_item.nmi    = res.nmi;
        push_item.vblank = res.vblank;
        case (res.src)
            prvp_pkg::SRC_OAM: push_item.rdata = mem_rd.oam;
            prvp_pkg::SRC_PAT: push_item.rdata = mem_rd.pat;
            prvp_pkg::SRC_NT:  push_item.rdata = mem_rd.nt;
            prvp_pkg::SRC_PAL: push_item.rdata = mem_rd.pal;
            default:           push_item.rdata = res.imm;
        endcase
    end

    assign push      = res.valid;
    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_item  = q_reg[rd_ptr_reg];
    assign room      = (cnt_reg + CNT_W'(res.valid)) < CNT_W'(prvp_pkg::QUEUE_DEPTH);
    assign level     = 3'(cnt_reg);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

endmodule

// ===== hw/rtl/ppu_register_and_vram_port_unit.sv =====
// cpu-facing register file and vram data port of the picture unit. each item is a dot tick,
// a register read or a register write; every item gives one result with the read byte, the
// nmi pulse and the vblank flag. one item is taken per clock while in_ready is high: the
// front updates the registers and issues the memory access in the accept cycle, the read
// data comes back in the next cycle and the result enters a four-entry output queue. after
// reset a clearing pass zeroes oam, pattern and nametable ram, during which in_ready stays
// low; configuration writes are taken at any time.
module ppu_register_and_vram_port_unit #(
    parameter int DOTS_PER_LINE   = prvp_pkg::DOTS_PER_LINE_DEF,
    parameter int LINES_PER_FRAME = prvp_pkg::LINES_PER_FRAME_DEF,
    parameter int VBLANK_LINE     = prvp_pkg::VBLANK_LINE_DEF,
    parameter int PATTERN_DEPTH   = prvp_pkg::PATTERN_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    input  logic [2:0] reg_sel,
    input  logic [7:0] wdata,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] rdata,
    output logic       nmi_pulse,
    output logic       vblank_flag,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       mirroring_mode
);

    prvp_pkg::mem_req_t mem_req;
    prvp_pkg::mem_rd_t  mem_rd;
    prvp_pkg::res_t     res;
    prvp_pkg::out_t     out_item;
    logic               clear_done;
    logic               room;
    logic [2:0]         level;

    assign cfg_ready = 1'b1;

    prvp_front #(
        .DOTS_PER_LINE   (DOTS_PER_LINE),
        .LINES_PER_FRAME (LINES_PER_FRAME),
        .VBLANK_LINE     (VBLANK_LINE),
        .PATTERN_DEPTH   (PATTERN_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .reg_sel    (reg_sel),
        .wdata      (wdata),
        .cfg_valid  (cfg_valid),
        .cfg_mirror (mirroring_mode),
        .clear_done (clear_done),
        .room       (room),
        .mem_req    (mem_req),
        .res        (res)
    );

    prvp_mem #(
        .PATTERN_DEPTH (PATTERN_DEPTH)
    ) u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .mem_req    (mem_req),
        .mem_rd     (mem_rd),
        .clear_done (clear_done)
    );

    prvp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .mem_rd    (mem_rd),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .level     (level)
    );

    assign rdata       = out_item.rdata;
    assign nmi_pulse   = out_item.nmi;
    assign vblank_flag = out_item.vblank;

    // no item enters while the clearing pass runs
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        !clear_done |-> !(in_valid && in_ready))
        else $error("item accepted during memory clear");

    // queue never overflows
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= 3'(prvp_pkg::QUEUE_DEPTH))
        else $error("output queue overflow");

    // an nmi result always carries vblank set
    a_nmi_has_vblank: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && nmi_pulse) |-> vblank_flag)
        else $error("nmi without vblank");

    // memory writes only happen for accepted items
    a_write_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_req.oam_we || mem_req.pat_we || mem_req.nt_we || mem_req.pal_we)
            |-> (in_valid && in_ready))
        else $error("memory write without item");

endmodule
